// ===== rtl/tmm_pkg.sv =====
// tmm_pkg: shared widths, command and register codes, and control types
// for the tiled matrix multiply core; no dependencies
package tmm_pkg;

    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_ELEM_WIDTH = 16;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    // wide enough to hold MAX_DIM at the top of its range
    localparam int DIM_CMP_W  = 9;

    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE = 3'd3;

    localparam logic [CFG_DATA_W-1:0] RST_ROWS_A    = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_INNER_DIM = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_COLS_B    = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_TILE_SIZE = 7'd16;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctrl;

endpackage

// ===== rtl/tmm_if.sv =====
// tmm_if: valid/ready channel interfaces for items, results and config writes
// depends on tmm_pkg
interface tmm_item_if;
    import tmm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    modport source (output valid, command, row, col, value, input ready);
    modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface tmm_result_if;
    import tmm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] product_sum;
    logic                    status;
    modport source (output valid, product_sum, status, input ready);
    modport sink   (input valid, product_sum, status, output ready);
endinterface

interface tmm_cfg_if;
    import tmm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tmm_store.sv =====
// tmm_store: element memories for A and B, one write and one registered read each
// depends on tmm_pkg
module tmm_store #(
    parameter int MAX_DIM    = tmm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = tmm_pkg::DEF_ELEM_WIDTH,
    parameter int AW         = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                         i_clk,
    input  logic                         i_we_a,
    input  logic                         i_we_b,
    input  logic [AW-1:0]                i_waddr,
    input  logic signed [ELEM_WIDTH-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr_a,
    input  logic [AW-1:0]                i_raddr_b,
    output logic signed [ELEM_WIDTH-1:0] o_rdata_a,
    output logic signed [ELEM_WIDTH-1:0] o_rdata_b
);
    import tmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [ELEM_WIDTH-1:0] r_mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem_a[i_raddr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_b <= r_mem_b[i_raddr_b];
        end
    end

endmodule

// ===== rtl/tmm_mac.sv =====
// tmm_mac: registered multiply then accumulate over elements read from the stores
// depends on tmm_pkg
module tmm_mac #(
    parameter int ELEM_WIDTH = tmm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tmm_pkg::t_mac_ctrl             i_ctrl,
    input  logic signed [ELEM_WIDTH-1:0]   i_rdata_a,
    input  logic signed [ELEM_WIDTH-1:0]   i_rdata_b,
    output logic signed [tmm_pkg::SUM_W-1:0] o_acc,
    output logic                           o_busy
);
    import tmm_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int XW = (PW > SUM_W) ? PW : SUM_W;

    logic                 r_rd_vld;
    logic                 r_prod_vld;
    logic signed [PW-1:0] r_prod;
    logic signed [XW-1:0] w_prod_ext;

    // sign extend, or wrap when the product is wider than the sum
    assign w_prod_ext = XW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_ctrl.issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_rdata_a * i_rdata_b;
        if (i_ctrl.clear) begin
            o_acc <= '0;
        end else if (r_prod_vld) begin
            o_acc <= o_acc + w_prod_ext[SUM_W-1:0];
        end
    end

    assign o_busy = r_rd_vld | r_prod_vld;

endmodule

// ===== rtl/tiled_matrix_multiply_core.sv =====
// tiled_matrix_multiply_core: top level, config registers, sequencer and result register
// depends on tmm_pkg, tmm_if, tmm_store, tmm_mac
//
//  channel    dir  handshake    payload
//  i_item     in   valid/ready  command, row, col, value
//  o_result   out  valid/ready  product_sum, status
//  i_cfg      in   valid/ready  index, data (always ready)
//
// write items give no result
// a compute item feeds one store read pair per cycle to the multiplier and accumulator,
// then waits for the read, product and add registers to drain and loads the result
// a compute with an index error, or inner_dim or tile_size zero or inner_dim above MAX_DIM,
// answers without a walk; inner_dim off the tile grid shows after the full walk
// reset is synchronous, active low; the stores keep no reset and need no clearing pass
// items are taken whenever the sequencer is idle, even with a result still waiting;
// a finished compute holds until the result register is free
module tiled_matrix_multiply_core #(
    parameter int MAX_DIM    = tmm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = tmm_pkg::DEF_ELEM_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tmm_item_if.sink     i_item,
    tmm_result_if.source o_result,
    tmm_cfg_if.sink      i_cfg
);
    import tmm_pkg::*;

    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int AXW = AW + IDX_W;
    localparam logic [DIM_CMP_W-1:0] MAXD = DIM_CMP_W'(MAX_DIM);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN,
        DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_rows_a;
    logic [CFG_DATA_W-1:0] r_inner;
    logic [CFG_DATA_W-1:0] r_cols_b;
    logic [CFG_DATA_W-1:0] r_tile;

    // compute sequencing
    logic [CFG_DATA_W-1:0] r_k;
    logic [CFG_DATA_W-1:0] r_rem;
    logic [AW-1:0]         r_addr_a;
    logic [AW-1:0]         r_addr_b;
    logic                  r_err;

    // result register
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_status;

    logic                         w_accept;
    logic                         w_row_lt_max;
    logic                         w_col_lt_max;
    logic                         w_a_ok;
    logic                         w_b_ok;
    logic                         w_size_bad;
    logic                         w_index_bad;
    logic                         w_we_a;
    logic                         w_we_b;
    logic [AXW-1:0]               w_row_base;
    logic [AW-1:0]                w_waddr;
    logic signed [ELEM_WIDTH-1:0] w_elem;
    logic signed [ELEM_WIDTH-1:0] w_rdata_a;
    logic signed [ELEM_WIDTH-1:0] w_rdata_b;
    logic signed [SUM_W-1:0]      w_acc;
    logic                         w_mac_busy;
    logic                         w_out_free;
    t_mac_ctrl                    w_mac_ctrl;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == IDLE);
    assign w_accept     = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= RST_ROWS_A;
            r_inner  <= RST_INNER_DIM;
            r_cols_b <= RST_COLS_B;
            r_tile   <= RST_TILE_SIZE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ROWS_A:    r_rows_a <= i_cfg.data;
                CFG_INNER_DIM: r_inner  <= i_cfg.data;
                CFG_COLS_B:    r_cols_b <= i_cfg.data;
                CFG_TILE_SIZE: r_tile   <= i_cfg.data;
                default:       ;
            endcase
        end
    end

    // range checks against configured sizes and the store geometry
    assign w_row_lt_max = DIM_CMP_W'(i_item.row) < MAXD;
    assign w_col_lt_max = DIM_CMP_W'(i_item.col) < MAXD;
    assign w_a_ok = (CFG_DATA_W'(i_item.row) < r_rows_a) && (CFG_DATA_W'(i_item.col) < r_inner)
                 && w_row_lt_max && w_col_lt_max;
    assign w_b_ok = (CFG_DATA_W'(i_item.row) < r_inner) && (CFG_DATA_W'(i_item.col) < r_cols_b)
                 && w_row_lt_max && w_col_lt_max;
    assign w_size_bad  = (r_inner == '0) || (DIM_CMP_W'(r_inner) > MAXD) || (r_tile == '0);
    assign w_index_bad = (CFG_DATA_W'(i_item.row) >= r_rows_a)
                      || (CFG_DATA_W'(i_item.col) >= r_cols_b)
                      || !w_row_lt_max || !w_col_lt_max;

    // flat address row * MAX_DIM + col, only used when both are in range
    assign w_row_base = AXW'(i_item.row) * AXW'(MAX_DIM);
    assign w_waddr    = AW'(w_row_base + AXW'(i_item.col));

    // stored element keeps the low element bits of value, or value sign extended when wider
    generate
        if (ELEM_WIDTH < VALUE_W) begin : g_narrow
            assign w_elem = i_item.value[ELEM_WIDTH-1:0];
        end else begin : g_wide
            assign w_elem = ELEM_WIDTH'(i_item.value);
        end
    endgenerate

    always_comb begin
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        if (w_accept) begin
            case (i_item.command)
                CMD_WRITE_A: w_we_a = w_a_ok;
                CMD_WRITE_B: w_we_b = w_b_ok;
                default:     ;
            endcase
        end
    end

    assign w_mac_ctrl.clear = w_accept && (i_item.command == CMD_COMPUTE);
    assign w_mac_ctrl.issue = (r_state == RUN);

    tmm_store #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we_a    (w_we_a),
        .i_we_b    (w_we_b),
        .i_waddr   (w_waddr),
        .i_wdata   (w_elem),
        .i_re      (w_mac_ctrl.issue),
        .i_raddr_a (r_addr_a),
        .i_raddr_b (r_addr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    tmm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_mac_ctrl),
        .i_rdata_a (w_rdata_a),
        .i_rdata_b (w_rdata_b),
        .o_acc     (w_acc),
        .o_busy    (w_mac_busy)
    );

    assign w_out_free = !r_out_valid || o_result.ready;

    // sequencer: k walks the inner dimension in increasing order, A address steps
    // by one, B address by a row; the remainder of inner_dim by tile_size is found
    // by repeated subtraction alongside, one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            // in DONE the load below decides the valid bit on its own
            if (r_out_valid && o_result.ready && (r_state != DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                IDLE: begin
                    if (w_accept && (i_item.command == CMD_COMPUTE)) begin
                        r_k      <= '0;
                        r_rem    <= r_inner;
                        r_addr_a <= AW'(w_row_base);
                        r_addr_b <= AW'(i_item.col);
                        if (w_size_bad || w_index_bad) begin
                            r_err   <= 1'b1;
                            r_state <= DONE;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= RUN;
                        end
                    end
                end
                RUN: begin
                    r_k      <= r_k + 1'b1;
                    r_addr_a <= r_addr_a + 1'b1;
                    r_addr_b <= r_addr_b + AW'(MAX_DIM);
                    if (r_rem >= r_tile) begin
                        r_rem <= r_rem - r_tile;
                    end
                    if (r_k == r_inner - 1'b1) begin
                        r_state <= DRAIN;
                    end
                end
                DRAIN: begin
                    // wait for the last product to land in the accumulator
                    if (!w_mac_busy) begin
                        r_err   <= (r_rem != '0);
                        r_state <= DONE;
                    end
                end
                DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_sum       <= r_err ? '0 : w_acc;
                        r_status    <= r_err;
                        r_state     <= IDLE;
                    end
                end
                default: r_state <= IDLE;
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.product_sum = r_sum;
    assign o_result.status      = r_status;

    // the stores are never written while a compute reads them
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != IDLE) |-> !(w_we_a || w_we_b))
        else $error("store written during compute");

    // a waiting result is not overwritten
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_sum)
                                              && $stable(r_status)))
        else $error("pending result changed");

    // the accumulator is settled whenever a result is loaded
    a_mac_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DONE) |-> !w_mac_busy)
        else $error("result loaded with products in flight");

    // the remainder search has finished by the end of the inner loop
    a_rem_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DRAIN) |-> (r_rem < r_tile))
        else $error("tile remainder not settled");

endmodule
